@@ sv/u2u8_pkg.sv @@
package u2u8_pkg;

    localparam int QUEUE_DEPTH = 2;
    localparam int JOB_BYTES   = 6;

    localparam logic [15:0] HIGH_FIRST = 16'hD800;
    localparam logic [15:0] HIGH_LAST  = 16'hDBFF;
    localparam logic [15:0] LOW_FIRST  = 16'hDC00;
    localparam logic [15:0] LOW_LAST   = 16'hDFFF;
    localparam logic [20:0] PLANE1     = 21'h10000;

    typedef struct packed {
        logic [15:0] code_unit;
        logic        last_unit;
    } unit_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_of_run;
        logic       end_of_string;
    } byte_t;

    // bytes[0] goes out first
    typedef struct packed {
        logic [JOB_BYTES-1:0][7:0] bytes;
        logic [2:0]                count;
        logic                      eos;
    } job_t;

    typedef struct packed {
        logic [3:0][7:0] b;
        logic [2:0]      len;
    } enc_t;

    function automatic enc_t encode(input logic [20:0] cp);
        enc_t e;
        e = '0;
        if (cp < 21'h80) begin
            e.b[0] = cp[7:0];
            e.len  = 3'd1;
        end else if (cp < 21'h800) begin
            e.b[0] = {3'b110, cp[10:6]};
            e.b[1] = {2'b10, cp[5:0]};
            e.len  = 3'd2;
        end else if (cp < PLANE1) begin
            e.b[0] = {4'b1110, cp[15:12]};
            e.b[1] = {2'b10, cp[11:6]};
            e.b[2] = {2'b10, cp[5:0]};
            e.len  = 3'd3;
        end else begin
            e.b[0] = {5'b11110, cp[20:18]};
            e.b[1] = {2'b10, cp[17:12]};
            e.b[2] = {2'b10, cp[11:6]};
            e.b[3] = {2'b10, cp[5:0]};
            e.len  = 3'd4;
        end
        return e;
    endfunction

endpackage

@@ sv/u2u8_stream_if.sv @@
interface u2u8_stream_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

@@ sv/u2u8_front.sv @@
module u2u8_front (
    input  logic                 clk,
    input  logic                 rst_n,
    u2u8_stream_if.sink          unit_in,
    input  logic                 queue_full,
    output logic                 push,
    output u2u8_pkg::job_t       push_job
);

    logic        held_valid_reg, held_valid_next;
    logic [9:0]  held_bits_reg, held_bits_next;
    logic        accept;
    logic        is_high, is_low;
    logic [15:0] unit;
    logic        last;
    logic [20:0] pair_cp;
    u2u8_pkg::enc_t flush_enc, unit_enc, pair_enc;

    assign unit    = unit_in.data.code_unit;
    assign last    = unit_in.data.last_unit;
    assign is_high = unit >= u2u8_pkg::HIGH_FIRST && unit <= u2u8_pkg::HIGH_LAST;
    assign is_low  = unit >= u2u8_pkg::LOW_FIRST && unit <= u2u8_pkg::LOW_LAST;

    assign unit_in.ready = !queue_full;
    assign accept        = unit_in.valid && unit_in.ready;

    assign pair_cp   = u2u8_pkg::PLANE1 + {1'b0, held_bits_reg, unit[9:0]};
    assign pair_enc  = u2u8_pkg::encode(pair_cp);
    assign flush_enc = u2u8_pkg::encode({5'd0, 6'b110110, held_bits_reg});
    assign unit_enc  = u2u8_pkg::encode({5'd0, unit});

    always_comb
    begin
        push_job     = '0;
        push_job.eos = last;
        held_valid_next = held_valid_reg;
        held_bits_next  = held_bits_reg;
        if (held_valid_reg && is_low)
        begin
            push_job.bytes[3:0] = pair_enc.b;
            push_job.count      = pair_enc.len;
        end
        else if (held_valid_reg)
        begin
            push_job.bytes[2:0] = flush_enc.b[2:0];
            push_job.count      = 3'd3;
            if (!(is_high && !last))
            begin
                push_job.bytes[5:3] = unit_enc.b[2:0];
                push_job.count      = 3'd3 + unit_enc.len;
            end
        end
        else if (!(is_high && !last))
        begin
            push_job.bytes[3:0] = unit_enc.b;
            push_job.count      = unit_enc.len;
        end
        if (accept)
        begin
            // hold a high surrogate that is not the string's end
            held_valid_next = is_high && !last;
            held_bits_next  = unit[9:0];
        end
    end

    assign push = accept && (push_job.count != 3'd0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_valid_reg <= 1'b0;
            held_bits_reg  <= '0;
        end
        else
        begin
            held_valid_reg <= held_valid_next;
            held_bits_reg  <= held_bits_next;
        end
    end

    a_last_never_held: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && last) |=> !held_valid_reg)
        else $error("surrogate held after last unit");

    a_push_count: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (push_job.count <= 3'(u2u8_pkg::JOB_BYTES)))
        else $error("job byte count out of range");

endmodule

@@ sv/u2u8_fifo.sv @@
module u2u8_fifo #(
    parameter int DEPTH = u2u8_pkg::QUEUE_DEPTH
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  u2u8_pkg::job_t  push_job,
    output logic            full,
    input  logic            pop,
    output logic            head_valid,
    output u2u8_pkg::job_t  head_job
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    u2u8_pkg::job_t mem [DEPTH];
    logic [PW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]  count_reg, count_next;

    assign full       = count_reg == CW'(DEPTH);
    assign head_valid = count_reg != '0;
    assign head_job   = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_job;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("push into full queue");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> head_valid)
        else $error("pop from empty queue");

endmodule

@@ sv/u2u8_back.sv @@
module u2u8_back (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            head_valid,
    input  u2u8_pkg::job_t  head_job,
    output logic            pop,
    u2u8_stream_if.source   byte_out
);

    logic       out_valid_reg, out_valid_next;
    logic [7:0] out_byte_reg, out_byte_next;
    logic       run_end_reg, run_end_next;
    logic       eos_reg, eos_next;
    logic [2:0] idx_reg, idx_next;
    logic       load;
    logic       last_byte;

    assign load      = head_valid && (!out_valid_reg || byte_out.ready);
    assign last_byte = idx_reg == (head_job.count - 3'd1);
    assign pop       = load && last_byte;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_byte_next  = out_byte_reg;
        run_end_next   = run_end_reg;
        eos_next       = eos_reg;
        idx_next       = idx_reg;
        if (byte_out.ready)
            out_valid_next = 1'b0;
        if (load)
        begin
            out_valid_next = 1'b1;
            out_byte_next  = head_job.bytes[idx_reg];
            run_end_next   = last_byte;
            eos_next       = last_byte && head_job.eos;
            // advance through the job, restart on the next one
            idx_next       = last_byte ? 3'd0 : idx_reg + 3'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            idx_reg       <= '0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            idx_reg       <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_byte_reg <= out_byte_next;
        run_end_reg  <= run_end_next;
        eos_reg      <= eos_next;
    end

    always_comb
    begin
        byte_out.valid              = out_valid_reg;
        byte_out.data.out_byte      = out_byte_reg;
        byte_out.data.last_of_run   = run_end_reg;
        byte_out.data.end_of_string = eos_reg;
    end

    a_idx_in_job: assert property (@(posedge clk) disable iff (!rst_n)
        head_valid |-> (idx_reg < head_job.count))
        else $error("byte index beyond job");

    a_eos_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && eos_reg) |-> run_end_reg)
        else $error("end of string inside a run");

endmodule

@@ sv/utf16_to_utf8_stream_unit.sv @@
// Channel    Dir  Payload                                   Item
// unit_in    in   code_unit[15:0], last_unit                one UTF-16 code unit
// byte_out   out  out_byte[7:0], last_of_run, end_of_string one UTF-8 byte
//
// unit_in takes one item per cycle while the job queue has room; it does not
// wait on byte_out. byte_out gives one byte per cycle, while ready is high and a
// job is queued, from a registered output stage; an item gives 1 to 6 bytes (0
// for a held high surrogate), and the byte side sets the sustained rate.
// rst_n clears the held surrogate, the job queue and the output stage.
// A stall on byte_out fills the QUEUE_DEPTH-entry job queue, then drops unit_in.ready.
module utf16_to_utf8_stream_unit #(
    parameter int QUEUE_DEPTH = u2u8_pkg::QUEUE_DEPTH
) (
    input  logic          clk,
    input  logic          rst_n,
    u2u8_stream_if.sink   unit_in,
    u2u8_stream_if.source byte_out
);

    logic           push;
    logic           pop;
    logic           full;
    logic           head_valid;
    u2u8_pkg::job_t push_job;
    u2u8_pkg::job_t head_job;

    u2u8_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .unit_in    (unit_in),
        .queue_full (full),
        .push       (push),
        .push_job   (push_job)
    );

    u2u8_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_job   (push_job),
        .full       (full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_job   (head_job)
    );

    u2u8_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_job   (head_job),
        .pop        (pop),
        .byte_out   (byte_out)
    );

endmodule
